// File: rtl/cks_pkg.sv
// shared types and codes for the capped ordered key set
// no dependencies

package cks_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned FLAG_W  = 20;
    localparam int unsigned SLOT_W  = 10;
    localparam int unsigned REQ_W   = 3;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned CNT_W   = 11;

    localparam logic [CNT_W-1:0]   MAX_ENTRIES_RST = 11'd1024;
    localparam logic [TOTAL_W-1:0] MAX_TOTAL_RST   = 32'hFFFF_FFFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD     = 3'd0,
        REQ_LOOKUP  = 3'd1,
        REQ_RM_KEY  = 3'd2,
        REQ_RM_POS  = 3'd3,
        REQ_READ    = 3'd4,
        REQ_CLEAR   = 3'd5
    } t_req;

    // configuration register indexes
    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_MAX_TOTAL   = 1'b1;

    typedef struct packed {
        logic latch;
        logic idx_clr;
        logic idx_inc;
        logic idx_load_slot;
        logic rd_idx;
        logic rd_next;
        logic rd_slot;
        logic rd_head;
        logic wr_shift;
        logic wr_new;
        logic pos_cap;
        logic cap_rm;
        logic pop_head;
        logic pop_tail;
        logic clear;
        logic done;
        logic res_found;
        logic res_idx;
        logic res_key;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             scan_end;
        logic             idx_last;
        logic             key_match;
        logic             slot_ok;
        logic             full;
        logic             empty;
        logic             need_evict;
    } t_dp_stat;

endpackage

// File: rtl/capped_ordered_key_set_core.sv
// top level of the capped ordered key set
// depends on cks_pkg, cks_ctrl, cks_dp (which holds cks_ram)

// One request is taken when start is high and busy low. Its single result is on the o_*
// ports for the one cycle that o_valid is high, and the receiver cannot stall it. busy is
// low again in that cycle, so the next request can be taken at the edge that ends it.
// After the accepting edge, a dispatch state comes first and a response state last, and
// the result is registered in the cycle after the response. Lookup, remove by key and add
// scan the entries from the oldest, reading one at a time through the one read port of the
// entry ram; a miss ends when the scan reaches the end. A removal closes the gap by moving
// each later entry one place. Add appends the new entry, first dropping the oldest entry
// when the store is full, then drops the oldest entries while a limit is exceeded. Read at
// a position reads the slot between dispatch and response; clear, an out-of-range position
// and an unknown request go from dispatch straight to the response. The set is empty after
// reset, no clearing pass is needed.
module capped_ordered_key_set_core #(
    parameter int unsigned CAPACITY = cks_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cks_pkg::REQ_W-1:0]     i_req_type,
    input  logic [cks_pkg::KEY_W-1:0]     i_key,
    input  logic [cks_pkg::FLAG_W-1:0]    i_flag,
    input  logic [cks_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [cks_pkg::TOTAL_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [cks_pkg::SLOT_W-1:0]    o_found_index,
    output logic [cks_pkg::KEY_W-1:0]     o_key_out,
    output logic [cks_pkg::CNT_W-1:0]     o_entry_count,
    output logic [cks_pkg::TOTAL_W-1:0]   o_flag_total
);
    import cks_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cks_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cks_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_flag        (i_flag),
        .i_slot_index  (i_slot_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_found_index (o_found_index),
        .o_key_out     (o_key_out),
        .o_entry_count (o_entry_count),
        .o_flag_total  (o_flag_total)
    );
endmodule

// File: rtl/cks_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module cks_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/cks_dp.sv
// datapath: entry ram as a circular buffer, head, count, weight sum, limits, result
// depends on cks_pkg and cks_ram

module cks_dp #(
    parameter int unsigned CAPACITY = cks_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cks_pkg::t_dp_cmd              i_cmd,
    output cks_pkg::t_dp_stat             o_stat,
    input  logic [cks_pkg::REQ_W-1:0]     i_req_type,
    input  logic [cks_pkg::KEY_W-1:0]     i_key,
    input  logic [cks_pkg::FLAG_W-1:0]    i_flag,
    input  logic [cks_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [cks_pkg::TOTAL_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [cks_pkg::SLOT_W-1:0]    o_found_index,
    output logic [cks_pkg::KEY_W-1:0]     o_key_out,
    output logic [cks_pkg::CNT_W-1:0]     o_entry_count,
    output logic [cks_pkg::TOTAL_W-1:0]   o_flag_total
);
    import cks_pkg::*;

    localparam int unsigned AW  = $clog2(CAPACITY);
    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned SW  = TOTAL_W + 1;
    localparam int unsigned DW  = KEY_W + FLAG_W;
    localparam int unsigned CMW = (CW > SLOT_W) ? ((CW > CNT_W) ? CW : CNT_W)
                                                : ((SLOT_W > CNT_W) ? SLOT_W : CNT_W);
    localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    function automatic logic [AW-1:0] pos2addr(input logic [AW-1:0] head,
                                               input logic [AW-1:0] pos);
        logic [AW:0] a;
        a = {1'b0, head} + {1'b0, pos};
        if (a >= CAP_A) begin
            a = a - CAP_A;
        end
        return a[AW-1:0];
    endfunction

    logic [REQ_W-1:0]   r_req;
    logic [KEY_W-1:0]   r_key;
    logic [FLAG_W-1:0]  r_flag;
    logic [SLOT_W-1:0]  r_slot;
    logic [CNT_W-1:0]   r_max_entries;
    logic [TOTAL_W-1:0] r_max_total;
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [SW-1:0]      r_sum;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_pos;
    logic [KEY_W-1:0]   r_rm_key;
    logic [FLAG_W-1:0]  r_rm_flag;

    logic               r_valid;
    logic               r_found;
    logic [CW-1:0]      r_found_pos;
    logic [KEY_W-1:0]   r_key_out;
    logic [CW-1:0]      r_cnt_out;
    logic [TOTAL_W-1:0] r_tot_out;

    logic [CW-1:0]      idx_next;
    logic [AW-1:0]      rd_pos;
    logic [AW-1:0]      wr_pos;
    logic               ram_re;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [AW-1:0]      ram_waddr;
    logic [DW-1:0]      ram_wdata;
    logic [DW-1:0]      ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [FLAG_W-1:0]  rd_flag;
    logic [CMW-1:0]     cmp_count;
    logic [CMW-1:0]     cmp_slot;
    logic [CMW-1:0]     cmp_max;
    logic [31:0]        fpos_wide;
    logic [31:0]        cnt_wide;

    assign idx_next  = r_idx + CW'(1);
    assign rd_key    = ram_rdata[DW-1:FLAG_W];
    assign rd_flag   = ram_rdata[FLAG_W-1:0];
    assign cmp_count = CMW'(r_count);
    assign cmp_slot  = CMW'(r_slot);
    assign cmp_max   = CMW'(r_max_entries);

    always_comb begin
        rd_pos = '0;
        if (i_cmd.rd_idx) begin
            rd_pos = r_idx[AW-1:0];
        end else if (i_cmd.rd_next) begin
            rd_pos = idx_next[AW-1:0];
        end else if (i_cmd.rd_slot) begin
            rd_pos = AW'(r_slot);
        end
        wr_pos = i_cmd.wr_new ? r_count[AW-1:0] : r_idx[AW-1:0];
    end

    assign ram_re    = i_cmd.rd_idx | i_cmd.rd_next | i_cmd.rd_slot | i_cmd.rd_head;
    assign ram_we    = i_cmd.wr_shift | i_cmd.wr_new;
    assign ram_raddr = pos2addr(r_head, rd_pos);
    assign ram_waddr = pos2addr(r_head, wr_pos);
    assign ram_wdata = i_cmd.wr_new ? {r_key, r_flag} : ram_rdata;

    cks_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_stat.req        = r_req;
        o_stat.scan_end   = (r_idx >= r_count);
        o_stat.idx_last   = (idx_next >= r_count);
        o_stat.key_match  = (rd_key == r_key);
        o_stat.slot_ok    = (cmp_slot < cmp_count);
        o_stat.full       = (r_count >= CAP_C);
        o_stat.empty      = (r_count == '0);
        o_stat.need_evict = (cmp_count > cmp_max) || (r_sum > SW'(r_max_total));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
            r_max_total   <= MAX_TOTAL_RST;
            r_head        <= '0;
            r_count       <= '0;
            r_sum         <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_ENTRIES) begin
                    r_max_entries <= i_cfg_data[CNT_W-1:0];
                end else begin
                    r_max_total <= i_cfg_data;
                end
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_sum   <= '0;
            end else if (i_cmd.wr_new) begin
                r_count <= r_count + CW'(1);
                r_sum   <= r_sum + SW'(r_flag);
            end else if (i_cmd.pop_head) begin
                r_head  <= pos2addr(r_head, AW'(1));
                r_count <= r_count - CW'(1);
                r_sum   <= r_sum - SW'(rd_flag);
            end else if (i_cmd.pop_tail) begin
                r_count <= r_count - CW'(1);
                r_sum   <= r_sum - SW'(r_rm_flag);
            end
            r_valid <= i_cmd.done;
        end
    end

    // payload, scan index, position and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req  <= i_req_type;
            r_key  <= i_key;
            r_flag <= i_flag;
            r_slot <= i_slot_index;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_load_slot) begin
            r_idx <= CW'(r_slot);
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_next;
        end
        if (i_cmd.idx_load_slot) begin
            r_pos <= CW'(r_slot);
        end else if (i_cmd.pos_cap) begin
            r_pos <= r_idx;
        end
        if (i_cmd.cap_rm) begin
            r_rm_key  <= rd_key;
            r_rm_flag <= rd_flag;
        end
        if (i_cmd.done) begin
            r_found     <= i_cmd.res_found;
            r_found_pos <= i_cmd.res_idx ? r_pos : '0;
            r_key_out   <= i_cmd.res_key ? r_rm_key : '0;
            r_cnt_out   <= r_count;
            r_tot_out   <= r_sum[TOTAL_W-1:0];
        end
    end

    assign fpos_wide     = 32'(r_found_pos);
    assign cnt_wide      = 32'(r_cnt_out);
    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_found_index = fpos_wide[SLOT_W-1:0];
    assign o_key_out     = r_key_out;
    assign o_entry_count = cnt_wide[CNT_W-1:0];
    assign o_flag_total  = r_tot_out;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");
    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_sum == '0)
        else $error("weight sum nonzero on empty set");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("back-to-back result strobes");
endmodule

// File: rtl/cks_ctrl.sv
// controller state machine: sequences scans, shifts and evictions
// depends on cks_pkg

module cks_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  cks_pkg::t_dp_stat i_stat,
    output cks_pkg::t_dp_cmd  o_cmd
);
    import cks_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_CMP, S_POSRD, S_SHIFT, S_SHWR,
        S_ADD_NEW, S_DROPF, S_ADD_WR, S_EVCHK, S_EVPOP, S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_res_found, n_res_found;
    logic   r_res_idx, n_res_idx;
    logic   r_res_key, n_res_key;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        n_res_key   = r_res_key;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_found = 1'b0;
                n_res_idx   = 1'b0;
                n_res_key   = 1'b0;
                case (i_stat.req) inside
                    REQ_ADD, REQ_LOOKUP, REQ_RM_KEY: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_SCAN;
                    end
                    REQ_RM_POS, REQ_READ: begin
                        if (i_stat.slot_ok) begin
                            o_cmd.idx_load_slot = 1'b1;
                            o_cmd.rd_slot       = 1'b1;
                            n_state             = S_POSRD;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RESP;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = (i_stat.req == REQ_ADD) ? S_ADD_NEW : S_RESP;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.key_match) begin
                    o_cmd.pos_cap = 1'b1;
                    o_cmd.cap_rm  = 1'b1;
                    case (i_stat.req)
                        REQ_LOOKUP: begin
                            n_res_found = 1'b1;
                            n_res_idx   = 1'b1;
                            n_state     = S_RESP;
                        end
                        REQ_RM_KEY: begin
                            n_res_found = 1'b1;
                            n_res_idx   = 1'b1;
                            n_state     = S_SHIFT;
                        end
                        default: begin
                            // duplicate add leaves everything as is
                            n_state = S_RESP;
                        end
                    endcase
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_POSRD: begin
                o_cmd.cap_rm = 1'b1;
                n_res_found  = 1'b1;
                n_res_idx    = 1'b1;
                n_res_key    = 1'b1;
                n_state      = (i_stat.req == REQ_RM_POS) ? S_SHIFT : S_RESP;
            end
            S_SHIFT: begin
                if (i_stat.idx_last) begin
                    o_cmd.pop_tail = 1'b1;
                    n_state        = S_RESP;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHIFT;
            end
            S_ADD_NEW: begin
                if (i_stat.full) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_DROPF;
                end else begin
                    n_state = S_ADD_WR;
                end
            end
            S_DROPF: begin
                o_cmd.pop_head = 1'b1;
                n_state        = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_cmd.wr_new = 1'b1;
                n_res_found  = 1'b1;
                n_state      = S_EVCHK;
            end
            S_EVCHK: begin
                if (!i_stat.empty && i_stat.need_evict) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_EVPOP;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_EVPOP: begin
                o_cmd.pop_head = 1'b1;
                n_state        = S_EVCHK;
            end
            S_RESP: begin
                o_cmd.done = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.res_found = r_res_found;
        o_cmd.res_idx   = r_res_idx;
        o_cmd.res_key   = r_res_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_found <= 1'b0;
            r_res_idx   <= 1'b0;
            r_res_key   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_found <= n_res_found;
            r_res_idx   <= n_res_idx;
            r_res_key   <= n_res_key;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_accept_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> r_state == S_DISPATCH)
        else $error("accepted transfer not dispatched");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> !o_busy)
        else $error("controller busy after result");
    a_ram_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_shift && o_cmd.wr_new))
        else $error("two ram writes in one cycle");
endmodule
